### src/wlc_pkg.sv
package wlc_pkg;

  localparam int WLC_MAX_SAMPLES = 8192;
  localparam int WLC_COS_BITS    = 10;

  localparam int WLC_CFG_W       = 32;
  localparam int WLC_CFG_IDX_W   = 2;
  localparam int WLC_COUNT_W     = 14;
  localparam int WLC_SAMPLE_W    = 9;
  localparam int WLC_QUEUE_DEPTH = 4;

  localparam logic [WLC_CFG_IDX_W-1:0] CFG_START_FREQ = 2'd0;
  localparam logic [WLC_CFG_IDX_W-1:0] CFG_SWEEP      = 2'd1;
  localparam logic [WLC_CFG_IDX_W-1:0] CFG_WINDOW     = 2'd2;
  localparam logic [WLC_CFG_IDX_W-1:0] CFG_COUNT      = 2'd3;

  localparam logic [31:0] START_FREQ_RST = 32'd450928616;
  localparam logic [31:0] SWEEP_RST      = 32'hFFFE_B075;
  localparam logic [31:0] WINDOW_RST     = 32'd859165;
  localparam logic [WLC_COUNT_W-1:0] COUNT_RST = 14'd5000;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] ONE_Q30    = 64'd1073741824;

  typedef struct packed {
    logic full;
    logic empty;
  } wlc_qstat_t;

  // First-quadrant cosine magnitude in Q15 for table entry k of a table with
  // 2^tbits entries per turn. Taylor series to the x^14 term in Q30.
  // Only evaluated at elaboration to build the lookup table.
  function automatic logic [14:0] wlc_cos_mag(input int unsigned k, input int unsigned tbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [65:0] sum;
    logic [65:0] v;
    x = (64'(k) * TWO_PI_Q30) >> tbits;
    x2 = (x * x) >> 30;
    term = ONE_Q30;
    sum = 66'(ONE_Q30);
    for (int j = 1; j <= 7; j++) begin
      term = (term * x2) >> 30;
      case (j)
        1: term = term / 64'd2;
        2: term = term / 64'd12;
        3: term = term / 64'd30;
        4: term = term / 64'd56;
        5: term = term / 64'd90;
        6: term = term / 64'd132;
        7: term = term / 64'd182;
        default: term = term;
      endcase
      if (j % 2 == 1) begin
        sum = sum - 66'(term);
      end else begin
        sum = sum + 66'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    v = (66'(sum) + 66'd16384) >> 15;
    if (v > 66'd32767) begin
      v = 66'd32767;
    end
    return v[14:0];
  endfunction

endpackage

### src/windowed_linear_chirp_generator_core.sv
// Channel  Direction  Word                      Handshake
// cfg      in         cfg_index, cfg_wdata      cfg_we, no back-pressure
// in       in         in_restart                in_valid / in_stall
// out      out        out_sample, out_last      out_valid / out_stall
//
// One word in and one sample out per clock when neither side stalls.
// An accepted word passes the queue, then the table read and the multiply,
// then is saturated into the output register; each step is registered.
// Reset clears the accumulators and loads the default register values.
// A four-word queue sits between the accumulator front end and the
// table/multiply pipeline, so an output stall only stalls the input once the
// queue has filled.
module windowed_linear_chirp_generator_core
  import wlc_pkg::*;
#(
  parameter int MAX_SAMPLES = WLC_MAX_SAMPLES,
  parameter int COS_BITS    = WLC_COS_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [WLC_CFG_IDX_W-1:0] cfg_index,
  input  logic [WLC_CFG_W-1:0]     cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_restart,
  output logic                     in_stall,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [WLC_SAMPLE_W-1:0]  out_sample,
  output logic                     out_last
);

  localparam int QW = 2 * COS_BITS + 1;

  wlc_qstat_t    q_stat;
  logic          q_push, q_pop;
  logic [QW-1:0] q_in, q_out;

  wlc_front #(.MAX_SAMPLES(MAX_SAMPLES), .COS_BITS(COS_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_restart (in_restart),
    .in_stall   (in_stall),
    .q_stat     (q_stat),
    .q_push     (q_push),
    .q_data     (q_in)
  );

  wlc_queue #(.W(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  wlc_back #(.COS_BITS(COS_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (q_out),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .out_last   (out_last)
  );

endmodule

### src/wlc_queue.sv
module wlc_queue
  import wlc_pkg::*;
#(
  parameter int W = 21
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output wlc_qstat_t   stat
);

  localparam int PW = $clog2(WLC_QUEUE_DEPTH);
  localparam int CW = $clog2(WLC_QUEUE_DEPTH + 1);

  logic [W-1:0]  store_r [WLC_QUEUE_DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wptr_nxt  = push ? wptr_r + PW'(1) : wptr_r;
    rptr_nxt  = pop ? rptr_r + PW'(1) : rptr_r;
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wptr_r] <= push_data;
    end
  end

  assign pop_data   = store_r[rptr_r];
  assign stat.full  = (count_r == CW'(WLC_QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

### src/wlc_front.sv
module wlc_front
  import wlc_pkg::*;
#(
  parameter int MAX_SAMPLES = WLC_MAX_SAMPLES,
  parameter int COS_BITS    = WLC_COS_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [WLC_CFG_IDX_W-1:0] cfg_index,
  input  logic [WLC_CFG_W-1:0]     cfg_wdata,
  input  logic                     in_valid,
  input  logic                     in_restart,
  output logic                     in_stall,
  input  wlc_qstat_t               q_stat,
  output logic                     q_push,
  output logic [2*COS_BITS:0]      q_data
);

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int CW = ($clog2(MAX_SAMPLES + 1) > WLC_COUNT_W) ?
                      $clog2(MAX_SAMPLES + 1) : WLC_COUNT_W;

  logic [31:0]            start_freq_r;
  logic [31:0]            sweep_r;
  logic [31:0]            window_r;
  logic [WLC_COUNT_W-1:0] count_r;

  logic [IW-1:0] idx_r, idx_nxt;
  logic [31:0]   cphase_r, cphase_nxt;
  logic [31:0]   freq_r, freq_nxt;
  logic [31:0]   wphase_r, wphase_nxt;

  logic          accept;
  logic [IW-1:0] cur_idx;
  logic [31:0]   cur_cphase, cur_freq, cur_wphase;
  logic [CW-1:0] count_ext, count_eff, last_lim;
  logic          last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_freq_r <= START_FREQ_RST;
      sweep_r      <= SWEEP_RST;
      window_r     <= WINDOW_RST;
      count_r      <= COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_FREQ: start_freq_r <= cfg_wdata;
        CFG_SWEEP:      sweep_r      <= cfg_wdata;
        CFG_WINDOW:     window_r     <= cfg_wdata;
        CFG_COUNT:      count_r      <= cfg_wdata[WLC_COUNT_W-1:0];
        default:        count_r      <= count_r;
      endcase
    end
  end

  assign in_stall = q_stat.full;
  assign accept   = in_valid & ~q_stat.full;
  assign q_push   = accept;

  always_comb begin
    cur_idx    = in_restart ? '0 : idx_r;
    cur_cphase = in_restart ? '0 : cphase_r;
    cur_freq   = in_restart ? start_freq_r : freq_r;
    cur_wphase = in_restart ? '0 : wphase_r;

    count_ext = CW'(count_r);
    if (count_ext < CW'(2)) begin
      count_eff = CW'(2);
    end else if (count_ext > CW'(MAX_SAMPLES)) begin
      count_eff = CW'(MAX_SAMPLES);
    end else begin
      count_eff = count_ext;
    end
    last_lim = count_eff - CW'(1);
    // A count lowered mid-chirp also ends the chirp at once.
    last = (CW'(cur_idx) >= last_lim);

    if (last) begin
      idx_nxt    = '0;
      cphase_nxt = '0;
      freq_nxt   = start_freq_r;
      wphase_nxt = '0;
    end else begin
      idx_nxt    = cur_idx + IW'(1);
      cphase_nxt = cur_cphase + cur_freq;
      freq_nxt   = cur_freq + sweep_r;
      wphase_nxt = cur_wphase + window_r;
    end
  end

  assign q_data = {cur_cphase[31 -: COS_BITS], cur_wphase[31 -: COS_BITS], last};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      cphase_r <= '0;
      freq_r   <= START_FREQ_RST;
      wphase_r <= '0;
    end else if (accept) begin
      idx_r    <= idx_nxt;
      cphase_r <= cphase_nxt;
      freq_r   <= freq_nxt;
      wphase_r <= wphase_nxt;
    end
  end

endmodule

### src/wlc_cos.sv
module wlc_cos
  import wlc_pkg::*;
#(
  parameter int COS_BITS = WLC_COS_BITS
) (
  input  logic                clk,
  input  logic                en,
  input  logic [COS_BITS-1:0] phase,
  output logic signed [15:0]  cos_val
);

  localparam int QUARTER = 1 << (COS_BITS - 2);
  localparam int KW      = COS_BITS - 1;

  logic [14:0] rom [QUARTER + 1];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    localparam logic [14:0] ENTRY = wlc_cos_mag(g, COS_BITS);
    assign rom[g] = ENTRY;
  end

  logic [COS_BITS-1:0] k_half, k_quad;
  logic                neg;
  logic [15:0]         mag;
  logic signed [15:0]  cos_r;

  // Fold the phase into the first quadrant; the second and third quadrants
  // take the sign.
  always_comb begin
    if (phase > COS_BITS'(2 * QUARTER)) begin
      k_half = COS_BITS'(0) - phase;
    end else begin
      k_half = phase;
    end
    if (k_half > COS_BITS'(QUARTER)) begin
      k_quad = COS_BITS'(2 * QUARTER) - k_half;
      neg    = 1'b1;
    end else begin
      k_quad = k_half;
      neg    = 1'b0;
    end
  end

  assign mag = {1'b0, rom[k_quad[KW-1:0]]};

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= neg ? -$signed(mag) : $signed(mag);
    end
  end

  assign cos_val = cos_r;

endmodule

### src/wlc_back.sv
module wlc_back
  import wlc_pkg::*;
#(
  parameter int COS_BITS = WLC_COS_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wlc_qstat_t              q_stat,
  input  logic [2*COS_BITS:0]     q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [WLC_SAMPLE_W-1:0] out_sample,
  output logic                    out_last
);

  logic adv_out, adv2, adv1;

  logic                     s1_v_r, s1_last_r;
  logic signed [15:0]       chirp_cos, win_cos;
  logic signed [17:0]       win_w;
  logic signed [33:0]       prod_nxt;
  logic                     s2_v_r, s2_last_r;
  logic signed [33:0]       prod_r;
  logic signed [34:0]       total;
  logic [10:0]              shifted;
  logic [WLC_SAMPLE_W-1:0]  sample_nxt;
  logic                     out_valid_r, out_last_r;
  logic [WLC_SAMPLE_W-1:0]  out_sample_r;

  assign adv_out = ~out_valid_r | ~out_stall;
  assign adv2    = ~s2_v_r | adv_out;
  assign adv1    = ~s1_v_r | adv2;
  assign q_pop   = ~q_stat.empty & adv1;

  wlc_cos #(.COS_BITS(COS_BITS)) u_chirp_cos (
    .clk     (clk),
    .en      (adv1),
    .phase   (q_data[2*COS_BITS -: COS_BITS]),
    .cos_val (chirp_cos)
  );

  wlc_cos #(.COS_BITS(COS_BITS)) u_win_cos (
    .clk     (clk),
    .en      (adv1),
    .phase   (q_data[COS_BITS -: COS_BITS]),
    .cos_val (win_cos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_last_r <= q_data[0];
    end
  end

  // Hann weight in Q16, 1..65535.
  assign win_w    = 18'sd32768 - 18'(win_cos);
  assign prod_nxt = 34'(chirp_cos) * 34'(win_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      prod_r    <= prod_nxt;
      s2_last_r <= s1_last_r;
    end
  end

  always_comb begin
    total   = 35'(prod_r) + 35'sd2147483648;
    shifted = total[34:24];
    if (total < 0) begin
      sample_nxt = '0;
    end else if (shifted > 11'd256) begin
      sample_nxt = WLC_SAMPLE_W'(256);
    end else begin
      sample_nxt = shifted[WLC_SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_sample_r <= sample_nxt;
      out_last_r   <= s2_last_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

### src/wlc_checker.sv
module wlc_checker
  import wlc_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [WLC_SAMPLE_W-1:0] out_sample,
  input logic                    out_last
);

  // The product never leaves the unsigned sample range.
  a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample <= WLC_SAMPLE_W'(256)))
    else $error("sample above full scale");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample) && $stable(out_last)))
    else $error("stalled output word changed");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word present right after reset");

  // The queue is empty after reset, so the input side is open.
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind windowed_linear_chirp_generator_core wlc_checker u_wlc_checker (.*);
